[hdl/assert_macros.svh]
// assertion macros used by utf8_name_hash_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define U8NH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define U8NH_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define U8NH_ASSERT(lbl, prop)
`define U8NH_ASSERT_NEVER(lbl, cond)
`endif
`endif

[hdl/u8nh_pkg.sv]
// types and constants of the utf-8 name hash unit
package u8nh_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned HashW  = 32;
  localparam int unsigned CharW  = 16;
  localparam int unsigned LeadW  = 5;
  localparam int unsigned SecW   = 6;

  localparam logic [5:0] HashMult = 6'd37;

  // decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_LEAD     = 4'b0001,
    PH_TWO_B2   = 4'b0010,
    PH_THREE_B2 = 4'b0100,
    PH_THREE_B3 = 4'b1000
  } phase_e;

  // decoder outcome for one byte
  typedef struct packed {
    logic               fold;
    logic               emit;
    logic [CharW-1:0]   ch;
    phase_e             phase_d;
    logic [LeadW-1:0]   lead_d;
    logic [SecW-1:0]    second_d;
  } dec_t;

endpackage

[hdl/utf8_name_hash_unit.sv]
// a terminating zero byte is taken into the byte register, and its hash is then loaded into the result register
// throughput: one byte per cycle while no name end is stalled; the byte register feeds the hash register directly
// a byte that ends a name waits in the byte register only while the previous hash is untaken
// the hash register updates as hash*37 + sign-extended character on each finished character and clears at a name's end
// reset (rst_ni low, asynchronous) empties both registers, clears the hash, expects a lead byte
`include "assert_macros.svh"

module utf8_name_hash_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [u8nh_pkg::ByteW-1:0]       name_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [u8nh_pkg::HashW-1:0]       name_hash_o
);
  import u8nh_pkg::*;

  logic               s1_valid_q;
  logic [ByteW-1:0]   s1_byte_q;
  phase_e             phase_q;
  logic [LeadW-1:0]   lead_q;
  logic [SecW-1:0]    second_q;
  logic [HashW-1:0]   hash_q, hash_d;
  logic               out_valid_q;
  logic [HashW-1:0]   out_hash_q;
  dec_t               dec;
  logic               out_free;
  logic               s1_adv;
  logic               in_fire;

  // decode of the held byte
  u8nh_decode u_decode (
    .phase_i  (phase_q),
    .lead_i   (lead_q),
    .second_i (second_q),
    .byte_i   (s1_byte_q),
    .dec_o    (dec)
  );

  // handshake: only an item that ends a name needs room in the result register
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!dec.emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // hash update
  always_comb begin
    hash_d = hash_q;
    if (dec.emit) begin
      hash_d = '0;
    end else if (dec.fold) begin
      hash_d = HashW'(hash_q * HashW'(HashMult))
             + {{(HashW-CharW){dec.ch[CharW-1]}}, dec.ch};
    end
  end

  // control and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_LEAD;
      lead_q      <= '0;
      second_q    <= '0;
      hash_q      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && dec.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        phase_q  <= dec.phase_d;
        lead_q   <= dec.lead_d;
        second_q <= dec.second_d;
        hash_q   <= hash_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= name_byte_i;
    end
    if (s1_adv && dec.emit) begin
      out_hash_q <= hash_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign name_hash_o = out_hash_q;

  // checks on the internal pipeline
  `U8NH_ASSERT(a_stall_only_on_emit, (s1_valid_q && !s1_adv) |-> (dec.emit && out_valid_q))
  `U8NH_ASSERT_NEVER(a_emit_outside_lead, dec.emit && (phase_q != PH_LEAD))
  `U8NH_ASSERT(a_hash_cleared, (s1_adv && dec.emit) |=> (hash_q == '0 && phase_q == PH_LEAD))
  `U8NH_ASSERT(a_result_loaded, (s1_adv && dec.emit) |=> (out_valid_q && out_hash_q == $past(hash_q)))

endmodule

[hdl/u8nh_decode.sv]
// utf-8 byte decoder: next phase, character assembly and end-of-name detection
module u8nh_decode (
  input  u8nh_pkg::phase_e                 phase_i,
  input  logic [u8nh_pkg::LeadW-1:0]       lead_i,
  input  logic [u8nh_pkg::SecW-1:0]        second_i,
  input  logic [u8nh_pkg::ByteW-1:0]       byte_i,
  output u8nh_pkg::dec_t                   dec_o
);
  import u8nh_pkg::*;

  always_comb begin
    dec_o          = '0;
    dec_o.phase_d  = PH_LEAD;
    dec_o.lead_d   = lead_i;
    dec_o.second_d = second_i;
    case (phase_i)
      // lead byte: plain character, start of a multi-byte form, or end of name
      PH_LEAD: begin
        if (byte_i == '0) begin
          dec_o.emit = 1'b1;
        end else if (!byte_i[7]) begin
          dec_o.fold = 1'b1;
          dec_o.ch   = {{(CharW-ByteW){1'b0}}, byte_i};
        end else if (byte_i[5]) begin
          dec_o.lead_d  = {1'b0, byte_i[3:0]};
          dec_o.phase_d = PH_THREE_B2;
        end else begin
          dec_o.lead_d  = byte_i[4:0];
          dec_o.phase_d = PH_TWO_B2;
        end
      end
      // last byte of a two-byte form
      PH_TWO_B2: begin
        dec_o.fold = 1'b1;
        dec_o.ch   = {5'b0, lead_i, byte_i[5:0]};
      end
      // middle byte of a three-byte form
      PH_THREE_B2: begin
        dec_o.second_d = byte_i[5:0];
        dec_o.phase_d  = PH_THREE_B3;
      end
      // last byte of a three-byte form
      PH_THREE_B3: begin
        dec_o.fold = 1'b1;
        dec_o.ch   = {lead_i[3:0], second_i, byte_i[5:0]};
      end
      default: begin
        dec_o.phase_d = PH_LEAD;
      end
    endcase
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the utf-8 name hash unit

module tb;
  import u8nh_pkg::*;

  localparam int unsigned NumRandom = 1150;
  localparam int unsigned NumDirected = 18;
  localparam int unsigned NumItems = NumDirected + NumRandom;

  // one queued input item, with its idling pace and an optional hold until drained
  typedef struct {
    logic [ByteW-1:0] value;
    logic             wait_drain;
    int unsigned      pace;
  } queued_byte_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ByteW-1:0]     name_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [HashW-1:0]     name_hash_o;

  queued_byte_t         byte_q[$];
  logic [HashW-1:0]     pending_hashes[$];
  int unsigned          queued_cnt = 0;
  int unsigned          err_count = 0;
  int unsigned          cur_pace = 0;

  // idle percentages per pace: sender then receiver
  int unsigned          tx_idle[3] = '{14, 56, 0};
  int unsigned          rx_idle[3] = '{56, 14, 0};

  // own copy of the decoder state
  phase_e               dec_phase = PH_LEAD;
  logic [4:0]           lead_pay = '0;
  logic [5:0]           cont_pay = '0;
  logic [HashW-1:0]     name_acc = '0;

  utf8_name_hash_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .name_byte_i (name_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .name_hash_o (name_hash_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("tb: mismatch: %s", msg);
    err_count++;
  endtask

  // decode one accepted byte and fold finished characters into the hash
  function void decode_name_byte(input logic [ByteW-1:0] b);
    logic [CharW-1:0] ch;
    logic             fold;
    fold = 1'b0;
    ch = '0;
    case (dec_phase)
      PH_LEAD: begin
        if (b == 8'h00) begin
          pending_hashes.push_back(name_acc);
          name_acc = '0;
        end else if (!b[7]) begin
          fold = 1'b1;
          ch = {8'h00, b};
        end else if (b[5]) begin
          lead_pay = {1'b0, b[3:0]};
          dec_phase = PH_THREE_B2;
        end else begin
          lead_pay = b[4:0];
          dec_phase = PH_TWO_B2;
        end
      end
      PH_TWO_B2: begin
        fold = 1'b1;
        ch = {5'b0, lead_pay, b[5:0]};
        dec_phase = PH_LEAD;
      end
      PH_THREE_B2: begin
        cont_pay = b[5:0];
        dec_phase = PH_THREE_B3;
      end
      default: begin
        fold = 1'b1;
        ch = {lead_pay[3:0], cont_pay, b[5:0]};
        dec_phase = PH_LEAD;
      end
    endcase
    if (fold) begin
      name_acc = name_acc * 32'd37 + {{(HashW-CharW){ch[CharW-1]}}, ch};
    end
  endfunction

  // queue one byte; the first byte of each new pace, or one queued with hold, waits for a drain
  task automatic push_byte(input logic [ByteW-1:0] b, input logic hold);
    queued_byte_t qb;
    int unsigned  pace;
    pace = (queued_cnt * 3) / NumItems;
    if (pace > 2) pace = 2;
    qb.value = b;
    qb.pace = pace;
    qb.wait_drain = hold || (queued_cnt != 0 && byte_q.size() != 0 &&
                             byte_q[byte_q.size()-1].pace != pace);
    byte_q.push_back(qb);
    queued_cnt++;
  endtask

  // driver: presents queued items, accepted bytes feed the predictor
  always @(posedge clk_i or negedge rst_ni) begin
    queued_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      name_byte_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) decode_name_byte(name_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() != 0 &&
            (!byte_q[0].wait_drain || pending_hashes.size() == 0) &&
            $urandom_range(0, 99) >= tx_idle[byte_q[0].pace]) begin
          nxt = byte_q.pop_front();
          in_valid_i <= 1'b1;
          name_byte_i <= nxt.value;
          cur_pace <= nxt.pace;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each hash checked against the oldest expected
  always @(posedge clk_i or negedge rst_ni) begin
    logic [HashW-1:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_hashes.size() == 0) begin
          flag_error($sformatf("unexpected hash %08h", name_hash_o));
        end else begin
          want = pending_hashes.pop_front();
          if (name_hash_o !== want) begin
            flag_error($sformatf("name_hash got %08h want %08h", name_hash_o, want));
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle[cur_pace]);
    end
  end

  // stimulus and end of run
  initial begin
    logic [ByteW-1:0] lead;
    int unsigned      nchars;
    int unsigned      sel;
    logic             hold;

    // empty name
    push_byte(8'h00, 1'b0);
    // ascii extremes
    push_byte(8'h7f, 1'b1);
    push_byte(8'h01, 1'b0);
    // largest two-byte character
    push_byte(8'hdf, 1'b0);
    push_byte(8'hbf, 1'b0);
    // malformed two-byte lead with a zero continuation
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    // 0xffff, folds as minus one
    push_byte(8'hef, 1'b0);
    push_byte(8'hbf, 1'b0);
    push_byte(8'hbf, 1'b0);
    // malformed three-byte lead, zero then all-ones continuation
    push_byte(8'ha0, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    // 0x8000, most negative character
    push_byte(8'he8, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    // back-to-back empty name
    push_byte(8'h00, 1'b0);

    // random names, some raw noise in between
    while (queued_cnt < NumItems) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 6)) push_byte(ByteW'($urandom_range(0, 255)), 1'b0);
      end else begin
        nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 8);
        hold = ($urandom_range(0, 49) == 0);
        repeat (nchars) begin
          sel = $urandom_range(0, 3);
          if (sel < 2) begin
            push_byte(ByteW'($urandom_range(1, 127)), hold);
            hold = 1'b0;
          end else begin
            // two-byte or three-byte lead, bit 6 either way
            lead = 8'h80 | (ByteW'($urandom_range(0, 1)) << 6)
                 | ByteW'($urandom_range(0, 31));
            lead[5] = (sel == 3);
            push_byte(lead, hold);
            hold = 1'b0;
            repeat (sel == 3 ? 2 : 1) begin
              if ($urandom_range(0, 7) == 0) push_byte(ByteW'($urandom_range(0, 255)), 1'b0);
              else push_byte(8'h80 | ByteW'($urandom_range(0, 63)), 1'b0);
            end
          end
        end
        push_byte(8'h00, hold);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
